### rtl/tlbpt_pkg.sv
`timescale 1ns / 1ps

package tlbpt_pkg;

  // Geometry
  localparam int TLB_ENTRIES      = 8;
  localparam int FRAME_COUNT      = 32;
  localparam int PAGE_NUMBER_BITS = 6;
  localparam int OFFSET_BITS      = 10;

  // Field widths
  localparam int VA_W     = 16;
  localparam int TIME_W   = 32;
  localparam int PHYS_W   = 15;
  localparam int STATUS_W = 2;

  localparam int PAGE_W     = PAGE_NUMBER_BITS;
  localparam int PAGE_COUNT = 1 << PAGE_W;
  localparam int FRAME_W    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int TLB_IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  // FIFO victim tree: one registered level per halving
  localparam int TREE_LEVELS = $clog2(TLB_ENTRIES);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int SETTLE_W    = (TREE_LEVELS > 0) ? $clog2(TREE_LEVELS + 1) : 1;

  // Stream widths
  localparam int IN_DATA_W  = ((VA_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PHYS_W + 7) / 8) * 8;
  localparam int OUT_USER_W = STATUS_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_TLB_HIT  = 2'd0,
    ST_PT_HIT   = 2'd1,
    ST_ALLOC    = 2'd2,
    ST_NO_FRAME = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tree_ready;
    logic out_free;
  } dp_sts_t;

  // Frame joined with offset, fitted to the physical address width
  function automatic logic [PHYS_W-1:0] join_addr(logic [FRAME_W-1:0]     frame,
                                                  logic [OFFSET_BITS-1:0] offset);
    logic [FRAME_W+OFFSET_BITS-1:0] joined;
    joined = {frame, offset};
    return PHYS_W'(joined);
  endfunction

endpackage

### rtl/tlbpt_ram.sv
`timescale 1ns / 1ps

module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tlbpt_ctrl.sv
`timescale 1ns / 1ps

module tlbpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output tlbpt_pkg::dp_cmd_t cmd,
  input  tlbpt_pkg::dp_sts_t sts
);
  import tlbpt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE
  } state_t;

  state_t state_r;
  logic   in_tready_r;

  // Commands
  assign cmd.capture = in_tvalid && in_tready_r && (state_r == S_IDLE);
  assign cmd.commit  = (state_r == S_DECIDE) && sts.tree_ready && sts.out_free;
  assign in_tready   = in_tready_r;

  // Sequencer: capture, look up, decide and commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tready_r && in_tvalid) begin
            state_r     <= S_LOOK;
            in_tready_r <= 1'b0;
          end else begin
            in_tready_r <= 1'b1;
          end
        end
        S_LOOK: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts.tree_ready && sts.out_free) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/tlbpt_dp.sv
`timescale 1ns / 1ps

module tlbpt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tlbpt_pkg::dp_cmd_t                   cmd,
  output tlbpt_pkg::dp_sts_t                   sts,
  input  logic [tlbpt_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tlbpt_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [tlbpt_pkg::OUT_USER_W-1:0]    out_tuser
);
  import tlbpt_pkg::*;

  typedef struct packed {
    logic                 present;
    logic [TIME_W-1:0]    birth;
    logic [TLB_IDX_W-1:0] idx;
  } node_t;

  // Older of two candidates; ties keep the lower index (left)
  function automatic node_t pick_older(node_t lhs, node_t rhs);
    if (rhs.present && (!lhs.present || (rhs.birth < lhs.birth))) begin
      return rhs;
    end
    return lhs;
  endfunction

  // Captured request
  logic [VA_W-1:0]   va_r;
  logic [TIME_W-1:0] time_r;

  // TLB
  logic [PAGE_W-1:0]  tlb_page_r  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_r [TLB_ENTRIES];
  logic [TIME_W-1:0]  tlb_birth_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;

  // Page table valid bits and frame map
  logic [PAGE_COUNT-1:0]  page_valid_r;
  logic [FRAME_COUNT-1:0] frame_used_r;

  // Lookup results, registered
  logic                 hit_r;
  logic [FRAME_W-1:0]   hit_frame_r;
  logic                 pvalid_r;
  logic                 free_any_r;
  logic [FRAME_W-1:0]   free_frame_r;
  logic                 inv_any_r;
  logic [TLB_IDX_W-1:0] inv_idx_r;

  logic                 hit;
  logic [FRAME_W-1:0]   hit_frame;
  logic                 free_any;
  logic [FRAME_W-1:0]   free_frame;
  logic                 inv_any;
  logic [TLB_IDX_W-1:0] inv_idx;

  logic [PAGE_W-1:0]      page;
  logic [OFFSET_BITS-1:0] offset;
  logic [VA_W-1:0]        va_shift;
  logic [FRAME_W-1:0]     pt_frame;

  // Victim tree
  node_t                 leaf [TREE_LEAVES];
  node_t                 victim_node;
  logic [TLB_IDX_W-1:0]  victim;
  logic [SETTLE_W-1:0]   settle_r;

  // Decision
  status_t            res_status;
  logic [FRAME_W-1:0] res_frame;
  logic               install;
  logic               alloc;

  // Output register
  logic               out_valid_r;
  logic [PHYS_W-1:0]  out_phys_r;
  status_t            out_status_r;

  // Address split
  assign va_shift = va_r >> OFFSET_BITS;
  assign page     = PAGE_W'(va_shift);
  assign offset   = va_r[OFFSET_BITS-1:0];

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      va_r   <= in_tdata[VA_W-1:0];
      time_r <= in_tdata[VA_W+TIME_W-1:VA_W];
    end
  end

  // Page table frames
  tlbpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGE_COUNT)
  ) u_page_frame (
    .clk   (clk),
    .we    (cmd.commit && alloc),
    .waddr (page),
    .wdata (free_frame_r),
    .raddr (page),
    .rdata (pt_frame)
  );

  // TLB match, lowest index wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_r[i] && (tlb_page_r[i] == page)) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_r[i];
      end
    end
  end

  // First invalid TLB entry
  always_comb begin
    inv_any = 1'b0;
    inv_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!tlb_valid_r[i]) begin
        inv_any = 1'b1;
        inv_idx = TLB_IDX_W'(i);
      end
    end
  end

  // Lowest free frame
  always_comb begin
    free_any   = 1'b0;
    free_frame = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (!frame_used_r[i]) begin
        free_any   = 1'b1;
        free_frame = FRAME_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r        <= hit;
    hit_frame_r  <= hit_frame;
    pvalid_r     <= page_valid_r[page];
    free_any_r   <= free_any;
    free_frame_r <= free_frame;
    inv_any_r    <= inv_any;
    inv_idx_r    <= inv_idx;
  end

  // Tree leaves; padding leaves never win
  for (genvar l = 0; l < TREE_LEAVES; l++) begin : g_leaf
    if (l < TLB_ENTRIES) begin : g_entry
      assign leaf[l] = '{present: 1'b1, birth: tlb_birth_r[l], idx: TLB_IDX_W'(l)};
    end else begin : g_pad
      assign leaf[l] = '{present: 1'b0, birth: '0, idx: '0};
    end
  end

  // Registered tree of oldest-birth compares, heap order
  if (TREE_LEAVES == 1) begin : g_flat
    assign victim_node = leaf[0];
  end else begin : g_tree
    node_t node_r [TREE_LEAVES-1];
    for (genvar n = 0; n < TREE_LEAVES - 1; n++) begin : g_node
      node_t lhs;
      node_t rhs;
      if (2 * n + 1 >= TREE_LEAVES - 1) begin : g_from_leaf
        assign lhs = leaf[2 * n + 1 - (TREE_LEAVES - 1)];
        assign rhs = leaf[2 * n + 2 - (TREE_LEAVES - 1)];
      end else begin : g_from_node
        assign lhs = node_r[2 * n + 1];
        assign rhs = node_r[2 * n + 2];
      end
      always_ff @(posedge clk) begin
        node_r[n] <= pick_older(lhs, rhs);
      end
    end
    assign victim_node = node_r[0];
  end

  assign victim = inv_any_r ? inv_idx_r : victim_node.idx;

  // Tree result is good once every level has seen the current births
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else if (cmd.commit && install) begin
      settle_r <= '0;
    end else if (settle_r != SETTLE_W'(TREE_LEVELS)) begin
      settle_r <= settle_r + 1'b1;
    end
  end

  // Outcome of the request
  always_comb begin
    res_status = ST_NO_FRAME;
    res_frame  = '0;
    install    = 1'b0;
    alloc      = 1'b0;
    priority if (hit_r) begin
      res_status = ST_TLB_HIT;
      res_frame  = hit_frame_r;
    end else if (pvalid_r) begin
      res_status = ST_PT_HIT;
      res_frame  = pt_frame;
      install    = 1'b1;
    end else if (free_any_r) begin
      res_status = ST_ALLOC;
      res_frame  = free_frame_r;
      install    = 1'b1;
      alloc      = 1'b1;
    end
  end

  // TLB entry contents
  always_ff @(posedge clk) begin
    if (cmd.commit && install) begin
      tlb_page_r[victim]  <= page;
      tlb_frame_r[victim] <= res_frame;
      tlb_birth_r[victim] <= time_r;
    end
  end

  // Valid bits and frame map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_valid_r  <= '0;
      page_valid_r <= '0;
      frame_used_r <= '0;
    end else if (cmd.commit) begin
      if (install) begin
        tlb_valid_r[victim] <= 1'b1;
      end
      if (alloc) begin
        page_valid_r[page]         <= 1'b1;
        frame_used_r[free_frame_r] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_phys_r   <= (res_status == ST_NO_FRAME) ? '0 : join_addr(res_frame, offset);
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = OUT_DATA_W'(out_phys_r);
  assign out_tuser      = out_status_r;
  assign sts.tree_ready = (settle_r == SETTLE_W'(TREE_LEVELS));
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

### rtl/tlb_page_table_translation_unit.sv
`timescale 1ns / 1ps

// Virtual to physical address translation: 8-entry fully associative TLB,
// FIFO replacement, backed by a 64-entry page table with on-demand
// allocation of the lowest free frame out of 32.
// Input channel (in_*): one item per request, virtual address and
// timestamp. Result channel (out_*): one item per request, physical
// address in out_tdata and the outcome (TLB hit, page table hit, frame
// allocated, no free frame) in out_tuser.
// Requests are handled one at a time. The result is registered after the
// look-up and decide steps, and in_tready comes back with it. When the
// previous item wrote the TLB, the decide step also waits while the
// registered oldest-entry tree (log2 of the TLB size levels) catches up.
// The result sits in an output register; the next request is taken while
// it waits. A stalled receiver holds the following result in the decide
// step and blocks new input only then.
// Synchronous reset clears the TLB, the page table and the frame map; the
// block opens in_tready in the cycle after reset is released.
module tlb_page_table_translation_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tlbpt_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] virtual_address,
                                                         // [47:16] request_time
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlbpt_pkg::OUT_DATA_W-1:0]   out_tdata,  // [14:0] physical_address
  output logic [tlbpt_pkg::OUT_USER_W-1:0]   out_tuser   // [1:0] status
);
  import tlbpt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tlbpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tlbpt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // One request in flight: taking an item closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a request is in flight");

  // A fresh result comes with the input reopening
  a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (in_tready && !$past(in_tready)))
    else $error("result produced outside the decide step");

  // Commit only when the victim tree has settled
  a_commit_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (sts.tree_ready && sts.out_free))
    else $error("commit before the victim choice settled");

  // No free frame gives a zero address
  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_NO_FRAME)) |-> (out_tdata == '0))
    else $error("nonzero address with no free frame");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tlbpt_pkg::*;

  localparam int ITEMS_PER_PHASE = 660;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int MAX_PRINTED     = 50;

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    status_t           st;
  } xlat_result_t;

  // One directed request; typed marks a hand-written expectation
  typedef struct packed {
    logic [VA_W-1:0]   va;
    logic [TIME_W-1:0] stamp;
    logic              typed;
    logic [PHYS_W-1:0] phys;
    status_t           st;
  } request_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // Shadow copy of the translation state
  logic [PAGE_W-1:0]  tlb_page_sh  [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame_sh [TLB_ENTRIES];
  logic               tlb_valid_sh [TLB_ENTRIES];
  logic [TIME_W-1:0]  tlb_birth_sh [TLB_ENTRIES];
  logic               page_valid_sh [PAGE_COUNT];
  logic [FRAME_W-1:0] page_frame_sh [PAGE_COUNT];
  logic               frame_used_sh [FRAME_COUNT];

  xlat_result_t pending_xlat_q [$];
  int           mismatch_count = 0;
  int           status_seen [4] = '{0, 0, 0, 0};
  int           send_idle = 21;
  int           recv_idle = 58;
  int           sent_count = 0;

  tlb_page_table_translation_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // FIFO install: first free slot, else oldest birth, lowest index on ties
  function automatic void tlb_fill(input logic [PAGE_W-1:0] pg,
                                   input logic [FRAME_W-1:0] frame,
                                   input logic [TIME_W-1:0] stamp);
    int victim;
    victim = 0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!tlb_valid_sh[i]) begin
        victim = i;
        break;
      end
      if (tlb_birth_sh[i] < tlb_birth_sh[victim]) victim = i;
    end
    tlb_page_sh[victim]  = pg;
    tlb_frame_sh[victim] = frame;
    tlb_valid_sh[victim] = 1'b1;
    tlb_birth_sh[victim] = stamp;
  endfunction

  function automatic xlat_result_t predict_translation(input logic [VA_W-1:0] va,
                                                       input logic [TIME_W-1:0] stamp);
    logic [PAGE_W-1:0]      pg;
    logic [OFFSET_BITS-1:0] ofs;
    logic [FRAME_W-1:0]     frame;
    xlat_result_t           res;
    pg  = va[OFFSET_BITS +: PAGE_W];
    ofs = va[OFFSET_BITS-1:0];
    // TLB lookup, lowest matching entry wins
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_valid_sh[i] && tlb_page_sh[i] == pg) begin
        res.phys = PHYS_W'({tlb_frame_sh[i], ofs});
        res.st   = ST_TLB_HIT;
        return res;
      end
    end
    // page table walk
    if (page_valid_sh[pg]) begin
      frame = page_frame_sh[pg];
      tlb_fill(pg, frame, stamp);
      res.phys = PHYS_W'({frame, ofs});
      res.st   = ST_PT_HIT;
      return res;
    end
    // allocate lowest free frame
    for (int f = 0; f < FRAME_COUNT; f++) begin
      if (!frame_used_sh[f]) begin
        frame = FRAME_W'(f);
        frame_used_sh[f]  = 1'b1;
        page_valid_sh[pg] = 1'b1;
        page_frame_sh[pg] = frame;
        tlb_fill(pg, frame, stamp);
        res.phys = PHYS_W'({frame, ofs});
        res.st   = ST_ALLOC;
        return res;
      end
    end
    res.phys = '0;
    res.st   = ST_NO_FRAME;
    return res;
  endfunction

  // Drive one request from a falling edge, hold until taken, then predict
  task automatic send_request(input request_row_t row);
    xlat_result_t want;
    @(negedge clk);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({row.stamp, row.va});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_translation(row.va, row.stamp);
    if (row.typed) begin
      want.phys = row.phys;
      want.st   = row.st;
    end
    pending_xlat_q.push_back(want);
    sent_count++;
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  // Result checker
  always @(posedge clk) begin : result_check
    xlat_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_xlat_q.size() == 0) begin
        report_mismatch($sformatf("result phys=%h status=%0d with no request pending",
                                  out_tdata[PHYS_W-1:0], out_tuser));
      end else begin
        want = pending_xlat_q.pop_front();
        status_seen[out_tuser]++;
        if (out_tdata[PHYS_W-1:0] !== want.phys) begin
          report_mismatch($sformatf("physical_address %h, expected %h",
                                    out_tdata[PHYS_W-1:0], want.phys));
        end
        if (out_tuser !== want.st) begin
          report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                    out_tuser, want.st, want.st.name()));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    request_row_t       dir_rows [15];
    request_row_t       row;
    logic [PAGE_W-1:0]  recent_pages [8];
    logic [TIME_W-1:0]  clock_stamp;
    logic [PAGE_W-1:0]  pg;
    int                 recent_wr;
    int                 pick;
    int                 guard;

    for (int i = 0; i < TLB_ENTRIES; i++) tlb_valid_sh[i] = 1'b0;
    for (int i = 0; i < PAGE_COUNT; i++) page_valid_sh[i] = 1'b0;
    for (int i = 0; i < FRAME_COUNT; i++) frame_used_sh[i] = 1'b0;
    for (int i = 0; i < 8; i++) recent_pages[i] = '0;
    recent_wr   = 0;
    clock_stamp = 32'd100;

    dir_rows = '{
      // first request after reset: top page, top offset, frame 0
      '{16'hFFFF, 32'h0000_0000, 1'b1, 15'h03FF, ST_ALLOC},
      // page 0 at the largest time stamp gets frame 1
      '{16'h0000, 32'hFFFF_FFFF, 1'b1, 15'h0400, ST_ALLOC},
      '{16'hFC00, 32'd5,         1'b1, 15'h0000, ST_TLB_HIT},
      '{16'h03FF, 32'd6,         1'b1, 15'h07FF, ST_TLB_HIT},
      '{16'h5555, 32'd7,         1'b1, 15'h0955, ST_ALLOC},
      '{16'hAAAA, 32'd7,         1'b1, 15'h0EAA, ST_ALLOC},
      // fill the rest of the TLB with equal birth times
      '{16'h0400, 32'd7,         1'b0, 15'h0000, ST_TLB_HIT},
      '{16'h0BFF, 32'd7,         1'b0, 15'h0000, ST_TLB_HIT},
      '{16'h0C01, 32'd7,         1'b0, 15'h0000, ST_TLB_HIT},
      '{16'h1200, 32'd7,         1'b0, 15'h0000, ST_TLB_HIT},
      // full TLB: evicts the oldest, then ties go to the lowest entry
      '{16'h1400, 32'd9,         1'b0, 15'h0000, ST_TLB_HIT},
      '{16'hFE00, 32'd10,        1'b0, 15'h0000, ST_TLB_HIT},
      '{16'h5400, 32'd11,        1'b0, 15'h0000, ST_TLB_HIT},
      '{16'h0001, 32'd12,        1'b0, 15'h0000, ST_TLB_HIT},
      '{16'hAAAB, 32'd13,        1'b0, 15'h0000, ST_TLB_HIT}
    };

    // synchronous reset
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    // random traffic in three phases: two stall profiles, then no stalls
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 21; recv_idle = 58; end
        1: begin send_idle = 58; recv_idle = 21; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        // mostly recently used pages so the TLB hits and evicts
        if (pick < 55) pg = recent_pages[$urandom_range(7)];
        else pg = PAGE_W'($urandom_range(PAGE_COUNT - 1));
        recent_pages[recent_wr] = pg;
        recent_wr = (recent_wr + 1) % 8;

        pick = $urandom_range(99);
        if (pick < 80) clock_stamp = clock_stamp + $urandom_range(1, 3);
        else if (pick < 90) clock_stamp = clock_stamp;
        else if (pick < 96) clock_stamp = $urandom;
        else clock_stamp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;

        row.va    = {pg, OFFSET_BITS'($urandom)};
        row.stamp = clock_stamp;
        row.typed = 1'b0;
        row.phys  = '0;
        row.st    = ST_TLB_HIT;
        send_request(row);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    recv_idle = 0;

    // drain
    guard = 0;
    while (pending_xlat_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_xlat_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_xlat_q.size()));
    end

    $display("Sent %0d requests: %0d TLB hits, %0d page table hits, %0d allocations, %0d refused",
             sent_count, status_seen[ST_TLB_HIT], status_seen[ST_PT_HIT],
             status_seen[ST_ALLOC], status_seen[ST_NO_FRAME]);
    $display("Stalls on input and output in both ratios, then back-to-back traffic");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
